@@ rtl/core/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants, sector codes and stage payload types of the
// hsv to rgb converter pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // hue fixed-point format
  localparam int HUE_FRAC_BITS = 8;
  localparam int HUE_W         = 17;
  localparam int CHAN_W        = 8;

  // degrees per sector and full circle, in hue units
  localparam int DIV_DEG       = 60;
  localparam int SECTOR_WIDTH  = DIV_DEG << HUE_FRAC_BITS;
  localparam int HUE_FULL      = 360 << HUE_FRAC_BITS;
  localparam int REM_W         = $clog2(SECTOR_WIDTH);

  // fraction within a sector, unsigned q0.16
  localparam int F_W           = 16;

  // remainder scaled so that f = x / 60
  localparam int X_W           = REM_W + F_W - HUE_FRAC_BITS;
  localparam int F_RECIP       = (2 ** X_W) / DIV_DEG;
  localparam int RECIP_W       = $clog2(F_RECIP + 1);

  // p, q and t numerators are 255 * 2^16 - sat * g
  localparam int CHAN_MAX      = 255;
  localparam int TERM_W        = CHAN_W + F_W;
  localparam int ONE_SCALED    = CHAN_MAX << F_W;
  localparam int NUM_TERMS     = 3;

  // hue sectors of 60 degrees
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

  // sector stage output
  typedef struct packed {
    sector_e             sector;
    logic [REM_W-1:0]    rem;
    logic [CHAN_W-1:0]   sat;
    logic [CHAN_W-1:0]   val;
  } sec_t;

  // fraction stage output
  typedef struct packed {
    sector_e             sector;
    logic [F_W-1:0]      f;
    logic [CHAN_W-1:0]   sat;
    logic [CHAN_W-1:0]   val;
  } frac_t;

  // one rgb pixel
  typedef struct packed {
    logic [CHAN_W-1:0]   blue;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   red;
  } rgb_t;

endpackage

@@ rtl/core/hsv2rgb_sector.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Zeroes out-of-range hue, finds its 60 degree sector and remainder in it.
// One register stage.
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue_i,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]      sat_i,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]      val_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output hsv2rgb_pkg::sec_t                   sec_o
);
  import hsv2rgb_pkg::*;

  logic             v_q;
  sec_t             sec_q;
  sec_t             sec_d;
  logic [HUE_W-1:0] hue_c;
  logic [HUE_W-1:0] base;
  logic             stage_rdy;

  // out-of-range hue to zero, sector compare and remainder
  always_comb begin
    hue_c = (hue_i >= HUE_W'(HUE_FULL)) ? '0 : hue_i;
    if (hue_c >= HUE_W'(5 * SECTOR_WIDTH)) begin
      sec_d.sector = SEC_5;
      base         = HUE_W'(5 * SECTOR_WIDTH);
    end else if (hue_c >= HUE_W'(4 * SECTOR_WIDTH)) begin
      sec_d.sector = SEC_4;
      base         = HUE_W'(4 * SECTOR_WIDTH);
    end else if (hue_c >= HUE_W'(3 * SECTOR_WIDTH)) begin
      sec_d.sector = SEC_3;
      base         = HUE_W'(3 * SECTOR_WIDTH);
    end else if (hue_c >= HUE_W'(2 * SECTOR_WIDTH)) begin
      sec_d.sector = SEC_2;
      base         = HUE_W'(2 * SECTOR_WIDTH);
    end else if (hue_c >= HUE_W'(SECTOR_WIDTH)) begin
      sec_d.sector = SEC_1;
      base         = HUE_W'(SECTOR_WIDTH);
    end else begin
      sec_d.sector = SEC_0;
      base         = '0;
    end
    sec_d.rem = REM_W'(hue_c - base);
    sec_d.sat = sat_i;
    sec_d.val = val_i;
  end

  assign stage_rdy = !v_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (stage_rdy) begin
      v_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (stage_rdy && valid_i) begin
      sec_q <= sec_d;
    end
  end

  assign ready_o = stage_rdy;
  assign valid_o = v_q;
  assign sec_o   = sec_q;

  // remainder always lies inside one sector
  a_rem_in_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (32'(sec_q.rem) < SECTOR_WIDTH && sec_q.sector <= SEC_5))
    else $error("sector stage remainder out of range");

endmodule

@@ rtl/core/hsv2rgb_frac.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_frac
// Turns the sector remainder into the q0.16 fraction f = x / 60 by a
// reciprocal multiply followed by a single correction step. Two stages.
// ----------------------------------------------------------------------------
module hsv2rgb_frac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsv2rgb_pkg::sec_t     sec_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsv2rgb_pkg::frac_t    frc_o
);
  import hsv2rgb_pkg::*;

  localparam int                 PROD_W  = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(F_RECIP);

  // estimate stage
  logic              va_q;
  logic [X_W-1:0]    x_q;
  logic [F_W-1:0]    est_q;
  sector_e           sector_a_q;
  logic [CHAN_W-1:0] sat_a_q;
  logic [CHAN_W-1:0] val_a_q;
  logic [X_W-1:0]    x_d;
  logic [PROD_W-1:0] prod;
  logic              rdy_a;

  // correction stage
  logic              vb_q;
  frac_t             frc_q;
  logic [X_W-1:0]    resid;
  logic [F_W-1:0]    f_d;
  logic              rdy_b;

  assign rdy_b = !vb_q || ready_i;
  assign rdy_a = !va_q || rdy_b;

  // scaled remainder times reciprocal of 60
  always_comb begin
    x_d  = X_W'(sec_i.rem) << (F_W - HUE_FRAC_BITS);
    prod = PROD_W'(x_d) * PROD_W'(RECIP_C);
  end

  // estimate is low by at most one, fix with one compare
  always_comb begin
    resid = x_q - X_W'(est_q) * X_W'(DIV_DEG);
    f_d   = (resid >= X_W'(DIV_DEG)) ? est_q + F_W'(1) : est_q;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      x_q        <= x_d;
      est_q      <= F_W'(prod >> X_W);
      sector_a_q <= sec_i.sector;
      sat_a_q    <= sec_i.sat;
      val_a_q    <= sec_i.val;
    end
    if (rdy_b && va_q) begin
      frc_q.sector <= sector_a_q;
      frc_q.f      <= f_d;
      frc_q.sat    <= sat_a_q;
      frc_q.val    <= val_a_q;
    end
  end

  assign ready_o = rdy_a;
  assign valid_o = vb_q;
  assign frc_o   = frc_q;

  // reciprocal estimate never misses by more than one step
  a_frac_resid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |-> (resid < X_W'(2 * DIV_DEG)))
    else $error("fraction estimate residue too large");

endmodule

@@ rtl/core/hsv2rgb_chan.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_chan
// Forms the p, q and t numerators, scales them by val, divides by
// 255 * 2^16 and maps the sector onto red, green and blue. Four stages.
// ----------------------------------------------------------------------------
module hsv2rgb_chan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsv2rgb_pkg::frac_t    frc_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsv2rgb_pkg::rgb_t     rgb_o
);
  import hsv2rgb_pkg::*;

  localparam int TERM_P = 0;
  localparam int TERM_Q = 1;
  localparam int TERM_T = 2;
  localparam int N_W    = CHAN_W + TERM_W;
  localparam int Z_W    = 16;
  localparam int ACC_W  = Z_W + CHAN_W;

  // numerator stage
  logic                                va_q;
  logic [NUM_TERMS-1:0][TERM_W-1:0]   m_q;
  logic [NUM_TERMS-1:0][TERM_W-1:0]   m_d;
  sector_e                             sector_a_q;
  logic [CHAN_W-1:0]                   val_a_q;
  logic [F_W:0]                        f_comp;
  logic [TERM_W:0]                     sf_t;
  logic [TERM_W-1:0]                   sf_f;

  // scale stage
  logic                                vb_q;
  logic [NUM_TERMS-1:0][Z_W-1:0]      zb_q;
  logic [NUM_TERMS-1:0][N_W-1:0]      n_d;
  sector_e                             sector_b_q;
  logic [CHAN_W-1:0]                   val_b_q;

  // divide estimate stage
  logic                                vc_q;
  logic [NUM_TERMS-1:0][Z_W-1:0]      zc_q;
  logic [NUM_TERMS-1:0][CHAN_W-1:0]   est_q;
  logic [NUM_TERMS-1:0][ACC_W-1:0]    acc;
  sector_e                             sector_c_q;
  logic [CHAN_W-1:0]                   val_c_q;

  // correction and select stage
  logic                                vd_q;
  rgb_t                                rgb_q;
  rgb_t                                rgb_d;
  logic [NUM_TERMS-1:0][Z_W-1:0]      resid;
  logic [NUM_TERMS-1:0][CHAN_W-1:0]   term;

  logic                                rdy_a;
  logic                                rdy_b;
  logic                                rdy_c;
  logic                                rdy_d;

  assign rdy_d = !vd_q || ready_i;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;

  // numerators 255 * 2^16 - sat * g for g = 2^16, f and 2^16 - f
  always_comb begin
    f_comp         = (F_W+1)'(1 << F_W) - (F_W+1)'(frc_i.f);
    sf_f           = TERM_W'(frc_i.sat) * TERM_W'(frc_i.f);
    sf_t           = (TERM_W+1)'(frc_i.sat) * (TERM_W+1)'(f_comp);
    m_d[TERM_P]    = {CHAN_W'(CHAN_MAX) - frc_i.sat, F_W'(0)};
    m_d[TERM_Q]    = TERM_W'(ONE_SCALED) - sf_f;
    m_d[TERM_T]    = TERM_W'((TERM_W+1)'(ONE_SCALED) - sf_t);
  end

  // val times numerator, drop the 2^16 scale
  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      n_d[k] = N_W'(val_a_q) * N_W'(m_q[k]);
    end
  end

  // divide by 255 through z * 257 / 2^16, low by at most one
  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      acc[k] = ACC_W'(zb_q[k]) + (ACC_W'(zb_q[k]) << CHAN_W);
    end
  end

  // correction step
  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      resid[k] = zc_q[k] - Z_W'(est_q[k]) * Z_W'(CHAN_MAX);
      term[k]  = (resid[k] >= Z_W'(CHAN_MAX)) ? est_q[k] + CHAN_W'(1) : est_q[k];
    end
  end

  // sector mapping
  always_comb begin
    case (sector_c_q)
      SEC_0: begin
        rgb_d.red = val_c_q;      rgb_d.green = term[TERM_T]; rgb_d.blue = term[TERM_P];
      end
      SEC_1: begin
        rgb_d.red = term[TERM_Q]; rgb_d.green = val_c_q;      rgb_d.blue = term[TERM_P];
      end
      SEC_2: begin
        rgb_d.red = term[TERM_P]; rgb_d.green = val_c_q;      rgb_d.blue = term[TERM_T];
      end
      SEC_3: begin
        rgb_d.red = term[TERM_P]; rgb_d.green = term[TERM_Q]; rgb_d.blue = val_c_q;
      end
      SEC_4: begin
        rgb_d.red = term[TERM_T]; rgb_d.green = term[TERM_P]; rgb_d.blue = val_c_q;
      end
      default: begin
        rgb_d.red = val_c_q;      rgb_d.green = term[TERM_P]; rgb_d.blue = term[TERM_Q];
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
      if (rdy_d) begin
        vd_q <= vc_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      m_q        <= m_d;
      sector_a_q <= frc_i.sector;
      val_a_q    <= frc_i.val;
    end
    if (rdy_b && va_q) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        zb_q[k] <= n_d[k][N_W-1 -: Z_W];
      end
      sector_b_q <= sector_a_q;
      val_b_q    <= val_a_q;
    end
    if (rdy_c && vb_q) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        est_q[k] <= acc[k][ACC_W-1 -: CHAN_W];
      end
      zc_q       <= zb_q;
      sector_c_q <= sector_b_q;
      val_c_q    <= val_b_q;
    end
    if (rdy_d && vc_q) begin
      rgb_q <= rgb_d;
    end
  end

  assign ready_o = rdy_a;
  assign valid_o = vd_q;
  assign rgb_o   = rgb_q;

  // quotient estimates are never off by more than one
  a_div_resid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> (resid[TERM_P] < Z_W'(2 * CHAN_MAX) && resid[TERM_Q] < Z_W'(2 * CHAN_MAX)
              && resid[TERM_T] < Z_W'(2 * CHAN_MAX)))
    else $error("channel divide residue too large");

  // p never exceeds val, so the mapped value channel is the largest
  a_p_below_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> (term[TERM_P] <= val_c_q))
    else $error("p term above value");

endmodule

@@ rtl/core/hsv_to_rgb_converter_core.sv @@
// Throughput: one beat per cycle while m_axis_tready keeps up, set by the 7-stage
// pipeline with per-stage valid bits.
// Backpressure: a stage advances when the stage after it is empty or moving, so
// bubbles collapse and a held output beat does not block upstream until the pipe fills.
// Reset: asynchronous active-low rst_ni clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Streaming hsv to rgb pixel converter: sector split, fraction and channel
// pipeline between a slave and a master stream port.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // hue_in[16:0], sat_in[24:17], val_in[32:25], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);
  import hsv2rgb_pkg::*;

  localparam int SAT_LO = HUE_W;
  localparam int VAL_LO = HUE_W + CHAN_W;

  logic              sec_valid;
  logic              sec_ready;
  sec_t              sec;
  logic              frc_valid;
  logic              frc_ready;
  frac_t             frc;
  rgb_t              rgb;
  logic [HUE_W-1:0]  hue_in;
  logic [CHAN_W-1:0] sat_in;
  logic [CHAN_W-1:0] val_in;

  // unpack the input beat
  assign hue_in = s_axis_tdata[HUE_W-1:0];
  assign sat_in = s_axis_tdata[SAT_LO +: CHAN_W];
  assign val_in = s_axis_tdata[VAL_LO +: CHAN_W];

  hsv2rgb_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .hue_i   (hue_in),
    .sat_i   (sat_in),
    .val_i   (val_in),
    .valid_o (sec_valid),
    .ready_i (sec_ready),
    .sec_o   (sec)
  );

  hsv2rgb_frac u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sec_valid),
    .ready_o (sec_ready),
    .sec_i   (sec),
    .valid_o (frc_valid),
    .ready_i (frc_ready),
    .frc_o   (frc)
  );

  hsv2rgb_chan u_chan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (frc_valid),
    .ready_o (frc_ready),
    .frc_i   (frc),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rgb_o   (rgb)
  );

  // pack the output beat
  assign m_axis_tdata = rgb;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streaming check of the hsv to rgb converter: hsv pixels go in on the
// slave port and each rgb beat is compared with a pixel predicted from
// the hue sector, the fraction within it and the p, q and t terms.
// ----------------------------------------------------------------------------
module testbench;
  import hsv2rgb_pkg::*;

  // scoreboard: predicts pixels from accepted beats and checks the outputs
  class rgb_scoreboard;
    rgb_t        expected_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // hsv to rgb in exact integer arithmetic, channels truncated
    function rgb_t convert_pixel(logic [HUE_W-1:0] hue, logic [CHAN_W-1:0] sat,
                                 logic [CHAN_W-1:0] val);
      longint unsigned h, rem, f, p, q, t, v, s, den;
      sector_e         sec;
      rgb_t            px;
      v   = 64'(val);
      s   = 64'(sat);
      h   = 64'(hue);
      den = longint'(CHAN_MAX) << F_W;
      if (s == 0) begin
        px.red   = val;
        px.green = val;
        px.blue  = val;
        return px;
      end
      // full circle and anything clamped to it wrap to zero
      if (h >= HUE_FULL) h = 0;
      sec = sector_e'(3'(h / SECTOR_WIDTH));
      rem = h % SECTOR_WIDTH;
      f   = (rem << F_W) / SECTOR_WIDTH;
      p   = (v * (CHAN_MAX - s)) / CHAN_MAX;
      q   = (v * (den - s * f)) / den;
      t   = (v * (den - s * ((longint'(1) << F_W) - f))) / den;
      case (sec)
        SEC_0: begin px.red = CHAN_W'(v); px.green = CHAN_W'(t); px.blue = CHAN_W'(p); end
        SEC_1: begin px.red = CHAN_W'(q); px.green = CHAN_W'(v); px.blue = CHAN_W'(p); end
        SEC_2: begin px.red = CHAN_W'(p); px.green = CHAN_W'(v); px.blue = CHAN_W'(t); end
        SEC_3: begin px.red = CHAN_W'(p); px.green = CHAN_W'(q); px.blue = CHAN_W'(v); end
        SEC_4: begin px.red = CHAN_W'(t); px.green = CHAN_W'(p); px.blue = CHAN_W'(v); end
        default: begin
          px.red = CHAN_W'(v); px.green = CHAN_W'(p); px.blue = CHAN_W'(q);
        end
      endcase
      return px;
    endfunction

    function void note_pixel(logic [HUE_W-1:0] hue, logic [CHAN_W-1:0] sat,
                             logic [CHAN_W-1:0] val);
      expected_q.push_back(convert_pixel(hue, sat, val));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task compare_channel(string chan, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] exp);
      if (got !== exp)
        report_mismatch($sformatf("%s got %0d expected %0d", chan, got, exp));
    endtask

    task check_pixel(rgb_t got);
      rgb_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", got));
        return;
      end
      exp = expected_q.pop_front();
      compare_channel("red", got.red, exp.red);
      compare_channel("green", got.green, exp.green);
      compare_channel("blue", got.blue, exp.blue);
    endtask
  endclass

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // hue_in[16:0], sat_in[24:17], val_in[32:25], zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // red_out[7:0], green_out[15:8], blue_out[23:16]

  rgb_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int pixels_seen;
  int hold_left;
  bit long_hold_done;
  int cycles;

  hsv_to_rgb_converter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // output beats checked as they are taken
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      sb.check_pixel(rgb_t'(m_axis_tdata));
      pixels_seen++;
    end
  end

  // receiver: random stalls plus one long hold-off once traffic is flowing
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && pixels_seen >= 300) begin
      long_hold_done = 1'b1;
      hold_left = 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one beat on the slave port, with random gaps ahead of it
  task send_pixel(logic [HUE_W-1:0] hue, logic [CHAN_W-1:0] sat, logic [CHAN_W-1:0] val);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, val, sat, hue};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_pixel(hue, sat, val);
  endtask

  // sender goes quiet until every pixel has come out
  task drain_pipe();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // random hue: mostly in range, some on sector edges, some above full circle
  function logic [HUE_W-1:0] pick_hue();
    int sel;
    int edge_hue;
    sel = $urandom_range(99);
    if (sel < 80) return HUE_W'($urandom_range(HUE_FULL));
    if (sel < 88) begin
      edge_hue = SECTOR_WIDTH * $urandom_range(6) + $urandom_range(2) - 1;
      if (edge_hue < 0) edge_hue = 0;
      return HUE_W'(edge_hue);
    end
    return HUE_W'($urandom_range((1 << HUE_W) - 1, HUE_FULL));
  endfunction

  function logic [CHAN_W-1:0] pick_chan();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 8'd0;
    if (sel < 15) return 8'd255;
    if (sel < 18) return 8'd1;
    return CHAN_W'($urandom_range(255));
  endfunction

  initial begin
    int k;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 6;
    recv_idle_pct  = 84;
    pixels_seen    = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    cycles         = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: grey, field extremes, sector edges, full circle and clamp
    send_pixel(17'd0, 8'd0, 8'd200);
    send_pixel(17'd50000, 8'd0, 8'd255);
    send_pixel(17'd0, 8'd255, 8'd255);
    send_pixel(17'd0, 8'd255, 8'd0);
    send_pixel(17'd0, 8'd1, 8'd255);
    for (k = 1; k <= 5; k++) begin
      send_pixel(HUE_W'(SECTOR_WIDTH * k - 1), 8'd255, 8'd255);
      send_pixel(HUE_W'(SECTOR_WIDTH * k), 8'd200, 8'd255);
    end
    send_pixel(HUE_W'(HUE_FULL - 1), 8'd255, 8'd255);
    send_pixel(HUE_W'(HUE_FULL), 8'd128, 8'd255);
    send_pixel(HUE_W'(HUE_FULL + 1), 8'd255, 8'd170);
    send_pixel(17'h1ffff, 8'd255, 8'd255);
    send_pixel(17'h1ffff, 8'd0, 8'd0);
    send_pixel(17'h0aaaa, 8'haa, 8'h55);
    send_pixel(17'h05555, 8'h55, 8'haa);

    // random traffic in three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 6;  recv_idle_pct = 84; end
        1: begin send_idle_pct = 84; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < 567; n++)
        send_pixel(pick_hue(), pick_chan(), pick_chan());
      if (phase == 0) drain_pipe();
    end

    drain_pipe();
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
